>>> rtl/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants of the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int IDX_W    = 6;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [ACT_W-1:0] {
    ACT_LIST = 2'd0,
    ACT_INS  = 2'd1,
    ACT_DEL  = 2'd2
  } act_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic [POS_W-1:0]          pos;
    logic [IDX_W-1:0]          last_idx;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

>>> rtl/positional_insert_delete_list_top.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list_top
// Ordered list of signed words with insert, delete and list commands.
// ----------------------------------------------------------------------------
// Commands enter on the input channel (in_valid_i / in_ready_o) and results
// leave on the output channel (out_valid_o / out_ready_i), each a transfer
// under a valid/ready handshake. One command is worked on at a time.
// An insert, an error result or an empty list loads its result in the execute
// state after its transfer; a delete loads its result in the delete state
// entered from the execute state, since the removed entry is gathered through
// a registered OR tree. A list command gives count results, the first loaded
// in the list state entered from the execute state and then one per cycle
// while the receiver takes them, read from the head of the cell chain as the
// chain rotates; after count steps the chain is back in order. The next
// command is taken once the output register is empty and control is idle.
// An unused action code gives no result.
// Reset clears the count and the control state; entries hold no reset value
// and are only read once written. A stalled receiver holds the result and
// stops the list rotation; no result is lost.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [pidl_pkg::ACT_W-1:0]         action_i,
  input  logic [pidl_pkg::POS_W-1:0]         position_i,
  input  logic signed [pidl_pkg::DATA_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pidl_pkg::STAT_W-1:0]        status_o,
  output logic signed [pidl_pkg::DATA_W-1:0] element_o,
  output logic [pidl_pkg::IDX_W-1:0]         index_o,
  output logic                               last_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_LIST = 4'b0100,
    S_DEL  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [pidl_pkg::ACT_W-1:0]         act_q;
  logic [pidl_pkg::POS_W-1:0]         pos_q;
  logic signed [pidl_pkg::DATA_W-1:0] val_q;
  logic [pidl_pkg::POS_W-1:0]         count_q, count_d;
  logic [pidl_pkg::IDX_W-1:0]         lidx_q, lidx_d;
  logic [pidl_pkg::POS_W-1:0]         cnt_m1;
  logic [pidl_pkg::IDX_W-1:0]         list_last;

  logic                               out_valid_q;
  logic [pidl_pkg::STAT_W-1:0]        status_q;
  logic signed [pidl_pkg::DATA_W-1:0] element_q;
  logic [pidl_pkg::IDX_W-1:0]         index_q;
  logic                               last_q;

  logic                               out_load;
  pidl_pkg::status_e                  o_status;
  logic signed [pidl_pkg::DATA_W-1:0] o_elem;
  logic [pidl_pkg::IDX_W-1:0]         o_idx;
  logic                               o_last;
  logic                               in_fire;

  pidl_pkg::cell_ctrl_t               ctrl;
  logic signed [pidl_pkg::DATA_W-1:0] data [pidl_pkg::CAPACITY];
  logic signed [pidl_pkg::DATA_W-1:0] pick [pidl_pkg::CAPACITY];
  logic signed [pidl_pkg::DATA_W-1:0] gone;

  assign cnt_m1    = count_q - pidl_pkg::POS_W'(1);
  assign list_last = cnt_m1[pidl_pkg::IDX_W-1:0];
  assign in_fire   = in_valid_i & in_ready_o;

  for (genvar c = 0; c < pidl_pkg::CAPACITY; c++) begin : g_cell
    logic signed [pidl_pkg::DATA_W-1:0] left_w;
    logic signed [pidl_pkg::DATA_W-1:0] right_w;
    if (c == 0) begin : g_first
      assign left_w = data[c];
    end else begin : g_mid_l
      assign left_w = data[c-1];
    end
    if (c == pidl_pkg::CAPACITY - 1) begin : g_end
      assign right_w = data[c];
    end else begin : g_mid_r
      assign right_w = data[c+1];
    end
    pidl_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (pidl_pkg::IDX_W'(c)),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (data[0]),
      .data_o  (data[c]),
      .pick_o  (pick[c])
    );
  end

  pidl_pick u_pick (
    .clk_i  (clk_i),
    .pick_i (pick),
    .gone_o (gone)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    lidx_d        = lidx_q;
    in_ready_o    = 1'b0;
    out_load      = 1'b0;
    o_status      = pidl_pkg::ST_OK;
    o_elem        = '0;
    o_idx         = '0;
    o_last        = 1'b1;
    ctrl.op       = pidl_pkg::OP_HOLD;
    ctrl.pos      = pos_q;
    ctrl.last_idx = list_last;
    ctrl.value    = val_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = ~out_valid_q;
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (act_q)
          pidl_pkg::ACT_LIST: begin
            if (count_q == '0) begin
              out_load = 1'b1;
              o_status = pidl_pkg::ST_EMPTY;
            end else begin
              lidx_d  = '0;
              state_d = S_LIST;
            end
          end
          pidl_pkg::ACT_INS: begin
            out_load = 1'b1;
            if (count_q == pidl_pkg::POS_W'(pidl_pkg::CAPACITY)) begin
              o_status = pidl_pkg::ST_FULL;
            end else if (pos_q > count_q) begin
              o_status = pidl_pkg::ST_BADPOS;
            end else begin
              o_idx   = pos_q[pidl_pkg::IDX_W-1:0];
              ctrl.op = pidl_pkg::OP_INS;
              count_d = count_q + pidl_pkg::POS_W'(1);
            end
          end
          pidl_pkg::ACT_DEL: begin
            if (count_q == '0) begin
              out_load = 1'b1;
              o_status = pidl_pkg::ST_EMPTY;
            end else if (pos_q >= count_q) begin
              out_load = 1'b1;
              o_status = pidl_pkg::ST_BADPOS;
            end else begin
              state_d = S_DEL;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DEL: begin
        out_load = 1'b1;
        o_elem   = gone;
        o_idx    = pos_q[pidl_pkg::IDX_W-1:0];
        ctrl.op  = pidl_pkg::OP_DEL;
        count_d  = cnt_m1;
        state_d  = S_IDLE;
      end
      S_LIST: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          o_elem   = data[0];
          o_idx    = lidx_q;
          o_last   = (lidx_q == list_last);
          ctrl.op  = pidl_pkg::OP_ROT;
          lidx_d   = lidx_q + pidl_pkg::IDX_W'(1);
          if (lidx_q == list_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      lidx_q  <= lidx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q <= action_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (out_load) begin
      status_q  <= o_status;
      element_q <= o_elem;
      index_q   <= o_idx;
      last_q    <= o_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign index_o     = index_q;
  assign last_o      = last_q;

endmodule

>>> rtl/pidl_cell.sv
// ----------------------------------------------------------------------------
// pidl_cell
// One list entry; moves data to or from its neighbors under a shared command.
// ----------------------------------------------------------------------------
module pidl_cell (
  input  logic                               clk_i,
  input  logic [pidl_pkg::IDX_W-1:0]         idx_i,
  input  pidl_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [pidl_pkg::DATA_W-1:0] left_i,
  input  logic signed [pidl_pkg::DATA_W-1:0] right_i,
  input  logic signed [pidl_pkg::DATA_W-1:0] head_i,
  output logic signed [pidl_pkg::DATA_W-1:0] data_o,
  output logic signed [pidl_pkg::DATA_W-1:0] pick_o
);

  logic signed [pidl_pkg::DATA_W-1:0] data_q;
  logic signed [pidl_pkg::DATA_W-1:0] data_d;
  logic [pidl_pkg::POS_W-1:0]         idx_ext;

  assign idx_ext = {1'b0, idx_i};

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      pidl_pkg::OP_INS: begin
        if (idx_ext > ctrl_i.pos) begin
          data_d = left_i;
        end else if (idx_ext == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      pidl_pkg::OP_DEL: begin
        if (idx_ext >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      pidl_pkg::OP_ROT: begin
        if (idx_i < ctrl_i.last_idx) begin
          data_d = right_i;
        end else if (idx_i == ctrl_i.last_idx) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign pick_o = (idx_ext == ctrl_i.pos) ? data_q : '0;

endmodule

>>> rtl/pidl_pick.sv
// ----------------------------------------------------------------------------
// pidl_pick
// Registered OR tree that gathers the entry selected for removal.
// ----------------------------------------------------------------------------
module pidl_pick (
  input  logic                               clk_i,
  input  logic signed [pidl_pkg::DATA_W-1:0] pick_i [pidl_pkg::CAPACITY],
  output logic signed [pidl_pkg::DATA_W-1:0] gone_o
);

  logic [pidl_pkg::DATA_W-1:0] grp_d [pidl_pkg::NGROUP];
  logic [pidl_pkg::DATA_W-1:0] grp_q [pidl_pkg::NGROUP];
  logic [pidl_pkg::DATA_W-1:0] sum;

  always_comb begin
    for (int g = 0; g < pidl_pkg::NGROUP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < pidl_pkg::GROUP; k++) begin
        if (g * pidl_pkg::GROUP + k < pidl_pkg::CAPACITY) begin
          grp_d[g] = grp_d[g] | pick_i[g * pidl_pkg::GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < pidl_pkg::NGROUP; g++) begin
      sum = sum | grp_q[g];
    end
  end

  assign gone_o = sum;

endmodule

>>> rtl/pidl_checker.sv
// ----------------------------------------------------------------------------
// pidl_checker
// Port-level checks of the positional insert/delete list.
// ----------------------------------------------------------------------------
module pidl_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [pidl_pkg::STAT_W-1:0]        status_o,
  input logic signed [pidl_pkg::DATA_W-1:0] element_o,
  input logic [pidl_pkg::IDX_W-1:0]         index_o,
  input logic                               last_o
);

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != pidl_pkg::ST_OK |-> last_o && element_o == '0 && index_o == '0)
    else $error("Error result is not a single cleared result.");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("A second command was taken while one is in work.");

  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("Command taken while a result is pending.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(element_o) && $stable(status_o))
    else $error("Stalled result changed.");

endmodule

bind positional_insert_delete_list_top pidl_checker u_pidl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .element_o   (element_o),
  .index_o     (index_o),
  .last_o      (last_o)
);
